FILE: rtl/h264_fu_a_packetizer_macros.svh
// Assertion macros shared by the FU-A packetizer RTL.
`ifndef H264_FU_A_PACKETIZER_MACROS_SVH
`define H264_FU_A_PACKETIZER_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define H264FU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked check that also holds during reset.
`define H264FU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

FILE: rtl/h264fu_pkg.sv
// Shared types and constants for the FU-A packetizer.
package h264fu_pkg;

  localparam int LENGTH_BITS_DEF = 16;
  localparam int MTU_W           = 16;
  localparam int MAXF_W          = 8;
  localparam int LIMIT_W         = MTU_W + MAXF_W;
  localparam int CFG_W           = 16;
  localparam int CFG_IDX_W       = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_MTU  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXF = 1'd1;

  localparam logic [MTU_W-1:0]   MTU_RESET   = 16'd1200;
  localparam logic [MAXF_W-1:0]  MAXF_RESET  = 8'd64;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64 * (1200 - 2));

  localparam logic [7:0] NRI_MASK  = 8'hE0;
  localparam logic [7:0] FU_A_TYPE = 8'd28;
  localparam logic [7:0] FU_START  = 8'h80;
  localparam logic [7:0] FU_END    = 8'h40;
  localparam logic [7:0] TYPE_MASK = 8'h1F;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // One classified request: what the back end has to emit for one input byte.
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] ind;
    logic [7:0] fuh;
    logic       has_hdr;
    logic       pend;
    logic       err;
  } h264fu_entry_t;

endpackage

FILE: rtl/h264fu_front.sv
// Front end: config registers, NAL tracking and per-byte classification.
`include "h264_fu_a_packetizer_macros.svh"
module h264fu_front import h264fu_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept_i,
  input  logic [7:0]             in_byte_i,
  input  logic [LENGTH_BITS-1:0] nal_length_i,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata,
  output logic                   push_o,
  output h264fu_entry_t          entry_o
);

  localparam int CW = (LENGTH_BITS > MTU_W ? LENGTH_BITS : MTU_W) + MAXF_W + 1;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_PASS = 2'd1;
  localparam logic [1:0] MODE_FRAG = 2'd2;
  localparam logic [1:0] MODE_DROP = 2'd3;

  logic [MTU_W-1:0]       mtu_r, mtu_nxt;
  logic [MAXF_W-1:0]      maxf_r, maxf_nxt;
  logic [LIMIT_W-1:0]     limit_r, limit_nxt;
  logic [MTU_W-1:0]       mul_a;
  logic [MAXF_W-1:0]      mul_b;

  logic [1:0]             mode_r, mode_nxt;
  logic [LENGTH_BITS-1:0] pos_r, pos_nxt;
  logic [LENGTH_BITS-1:0] latched_r, latched_nxt;
  logic [MTU_W-1:0]       off_r, off_nxt;
  logic [7:0]             held_r, held_nxt;

  logic                   mtu_small;
  logic [MTU_W-1:0]       chunk;
  logic                   last;
  logic                   pend;
  logic [7:0]             fuh;

  // Fragment limit kept as max_fragments * (mtu - 2), refreshed on each write.
  always_comb begin
    mtu_nxt  = mtu_r;
    maxf_nxt = maxf_r;
    mul_a    = mtu_r - MTU_W'(2);
    mul_b    = maxf_r;
    if (cfg_we && cfg_index == CFG_MTU) begin
      mtu_nxt = cfg_wdata[MTU_W-1:0];
      mul_a   = cfg_wdata[MTU_W-1:0] - MTU_W'(2);
    end
    if (cfg_we && cfg_index == CFG_MAXF) begin
      maxf_nxt = cfg_wdata[MAXF_W-1:0];
      mul_b    = cfg_wdata[MAXF_W-1:0];
    end
    limit_nxt = {{MAXF_W{1'b0}}, mul_a} * {{MTU_W{1'b0}}, mul_b};
  end

  always_comb begin
    mtu_small = mtu_r < MTU_W'(3);
    chunk     = mtu_small ? MTU_W'(1) : mtu_r - MTU_W'(2);
    last      = (CW'(pos_r) + CW'(1)) >= CW'(latched_r);
    pend      = last || ((CW'(off_r) + CW'(1)) >= CW'(chunk));
    fuh       = held_r & TYPE_MASK;
    if (pos_r == LENGTH_BITS'(1)) begin
      fuh = fuh | FU_START;
    end
    if ((CW'(latched_r) - CW'(pos_r)) <= CW'(chunk)) begin
      fuh = fuh | FU_END;
    end

    mode_nxt    = mode_r;
    pos_nxt     = pos_r;
    latched_nxt = latched_r;
    off_nxt     = off_r;
    held_nxt    = held_r;
    push_o      = 1'b0;
    entry_o     = '0;
    entry_o.data = in_byte_i;

    if (accept_i) begin
      if (mode_r == MODE_IDLE) begin
        latched_nxt = nal_length_i;
        if (nal_length_i == '0 || mtu_small) begin
          push_o      = 1'b1;
          entry_o.err = 1'b1;
          if (nal_length_i > LENGTH_BITS'(1)) begin
            mode_nxt = MODE_DROP;
            pos_nxt  = LENGTH_BITS'(1);
          end
        end else if (CW'(nal_length_i) <= CW'(mtu_r)) begin
          push_o       = 1'b1;
          entry_o.pend = (nal_length_i == LENGTH_BITS'(1));
          if (nal_length_i > LENGTH_BITS'(1)) begin
            mode_nxt = MODE_PASS;
            pos_nxt  = LENGTH_BITS'(1);
          end
        end else if ((CW'(nal_length_i) - CW'(1)) > CW'(limit_r)) begin
          push_o      = 1'b1;
          entry_o.err = 1'b1;
          mode_nxt    = MODE_DROP;
          pos_nxt     = LENGTH_BITS'(1);
        end else begin
          held_nxt = in_byte_i;
          mode_nxt = MODE_FRAG;
          pos_nxt  = LENGTH_BITS'(1);
          off_nxt  = '0;
        end
      end else begin
        case (mode_r)
          MODE_PASS: begin
            push_o       = 1'b1;
            entry_o.pend = last;
          end
          MODE_FRAG: begin
            push_o          = 1'b1;
            entry_o.pend    = pend;
            entry_o.has_hdr = (off_r == '0);
            entry_o.ind     = (held_r & NRI_MASK) | FU_A_TYPE;
            entry_o.fuh     = fuh;
            off_nxt         = pend ? '0 : off_r + MTU_W'(1);
          end
          default: begin
          end
        endcase
        if (last) begin
          mode_nxt = MODE_IDLE;
          pos_nxt  = '0;
          off_nxt  = '0;
        end else begin
          pos_nxt = pos_r + LENGTH_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mtu_r     <= MTU_RESET;
      maxf_r    <= MAXF_RESET;
      limit_r   <= LIMIT_RESET;
      mode_r    <= MODE_IDLE;
      pos_r     <= '0;
      latched_r <= '0;
      off_r     <= '0;
      held_r    <= '0;
    end else begin
      mtu_r     <= mtu_nxt;
      maxf_r    <= maxf_nxt;
      if (cfg_we) begin
        limit_r <= limit_nxt;
      end
      mode_r    <= mode_nxt;
      pos_r     <= pos_nxt;
      latched_r <= latched_nxt;
      off_r     <= off_nxt;
      held_r    <= held_nxt;
    end
  end

  `H264FU_ASSERT(a_idle_clear, (mode_r == MODE_IDLE) |-> (pos_r == '0 && off_r == '0), "idle with stale position")

endmodule

FILE: rtl/h264fu_queue.sv
// Small request queue between the front and back ends.
`include "h264_fu_a_packetizer_macros.svh"
module h264fu_queue import h264fu_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_i,
  input  h264fu_entry_t entry_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          valid_o,
  output h264fu_entry_t head_o
);

  h264fu_entry_t    slots_r [QDEPTH];
  logic [QAW-1:0]   wr_r, wr_nxt;
  logic [QAW-1:0]   rd_r, rd_nxt;
  logic [QAW:0]     cnt_r, cnt_nxt;

  assign full_o  = (cnt_r == (QAW+1)'(QDEPTH));
  assign valid_o = (cnt_r != '0);
  assign head_o  = slots_r[rd_r];

  always_comb begin
    wr_nxt  = push_i ? wr_r + QAW'(1) : wr_r;
    rd_nxt  = pop_i ? rd_r + QAW'(1) : rd_r;
    cnt_nxt = cnt_r;
    if (push_i && !pop_i) begin
      cnt_nxt = cnt_r + (QAW+1)'(1);
    end else if (pop_i && !push_i) begin
      cnt_nxt = cnt_r - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      slots_r[wr_r] <= entry_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  `H264FU_ASSERT(a_no_overflow, full_o |-> !push_i, "push into full queue")
  `H264FU_ASSERT(a_no_underflow, pop_i |-> valid_o, "pop from empty queue")
  `H264FU_ASSERT(a_cnt_range, cnt_r <= (QAW+1)'(QDEPTH), "queue count out of range")

endmodule

FILE: rtl/h264fu_back.sv
// Back end: expands queued requests into packet bytes behind an output register.
`include "h264_fu_a_packetizer_macros.svh"
module h264fu_back import h264fu_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid_i,
  input  h264fu_entry_t q_head_i,
  output logic          q_pop_o,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output logic [7:0]    out_byte_o,
  output logic          packet_end_o,
  output logic          item_last_o,
  output logic          error_o
);

  localparam logic [1:0] PH_IND  = 2'd0;
  localparam logic [1:0] PH_FUH  = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;

  logic [1:0] phase_r, phase_nxt;
  logic       ov_r, ov_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       pend_r, pend_nxt;
  logic       item_r, item_nxt;
  logic       err_r, err_nxt;
  logic       load;
  logic       last_phase;

  assign load        = q_valid_i && (!ov_r || out_ready_i);
  assign last_phase  = !q_head_i.has_hdr || (phase_r == PH_DATA);
  assign q_pop_o     = load && last_phase;

  assign out_valid_o  = ov_r;
  assign out_byte_o   = byte_r;
  assign packet_end_o = pend_r;
  assign item_last_o  = item_r;
  assign error_o      = err_r;

  always_comb begin
    byte_nxt = q_head_i.data;
    pend_nxt = q_head_i.pend;
    item_nxt = 1'b1;
    err_nxt  = 1'b0;
    if (q_head_i.err) begin
      byte_nxt = '0;
      pend_nxt = 1'b0;
      err_nxt  = 1'b1;
    end else if (q_head_i.has_hdr) begin
      case (phase_r)
        PH_IND: begin
          byte_nxt = q_head_i.ind;
          pend_nxt = 1'b0;
          item_nxt = 1'b0;
        end
        PH_FUH: begin
          byte_nxt = q_head_i.fuh;
          pend_nxt = 1'b0;
          item_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end

    ov_nxt    = load ? 1'b1 : (out_ready_i ? 1'b0 : ov_r);
    phase_nxt = phase_r;
    if (load) begin
      phase_nxt = last_phase ? PH_IND : phase_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_nxt;
      pend_r <= pend_nxt;
      item_r <= item_nxt;
      err_r  <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r    <= 1'b0;
      phase_r <= PH_IND;
    end else begin
      ov_r    <= ov_nxt;
      phase_r <= phase_nxt;
    end
  end

  `H264FU_ASSERT(a_phase_hdr, (phase_r != PH_IND) |-> (q_valid_i && q_head_i.has_hdr), "header phase without header request")

endmodule

FILE: rtl/h264_fu_a_packetizer.sv
// Top level of the RTP H.264 FU-A packetizer.
//
//  channel | direction | tdata (low bit up)                  | tuser  | tlast
//  in_     | slave     | in_byte, nal_length                 | -      | -
//  out_    | master    | out_byte, item_last, zero pad       | error  | packet_end
//  cfg_    | write     | index 0 mtu_bytes, 1 max_fragments  | -      | -
//
// One input byte per cycle is taken while the four-entry request queue has room.
// Output runs one byte per cycle while out_tready is high; the first payload byte of an
// FU-A packet is preceded by its indicator and FU header bytes, so sustained input rate is set by the output side.
// A request passes a queue slot and then the back-end output register before output.
// rst_n is synchronous; config returns to mtu 1200, max fragments 64.
module h264_fu_a_packetizer import h264fu_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [7:0] in_byte, then nal_length, then zero pad
  input  logic [((8+LENGTH_BITS+7)/8)*8-1:0] in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [7:0] out_byte, [8] item_last, [15:9] zero
  output logic [15:0]                        out_tdata,
  // [0] error
  output logic                               out_tuser,
  output logic                               out_tlast,
  input  logic                               cfg_we,
  input  logic [CFG_IDX_W-1:0]               cfg_index,
  input  logic [CFG_W-1:0]                   cfg_wdata
);

  logic          accept;
  logic          push;
  h264fu_entry_t entry;
  logic          q_full;
  logic          q_valid;
  logic          q_pop;
  h264fu_entry_t q_head;
  logic [7:0]    out_byte;
  logic          item_last;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign out_tdata = {7'b0, item_last, out_byte};

  h264fu_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept_i    (accept),
    .in_byte_i   (in_tdata[7:0]),
    .nal_length_i(in_tdata[8 +: LENGTH_BITS]),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .push_o      (push),
    .entry_o     (entry)
  );

  h264fu_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (push),
    .entry_i(entry),
    .pop_i  (q_pop),
    .full_o (q_full),
    .valid_o(q_valid),
    .head_o (q_head)
  );

  h264fu_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_ready_i (out_tready),
    .out_valid_o (out_tvalid),
    .out_byte_o  (out_byte),
    .packet_end_o(out_tlast),
    .item_last_o (item_last),
    .error_o     (out_tuser)
  );

endmodule
